[src/rfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational fraction ALU package
// Shared widths, codes and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int OpW  = 16;
  localparam int ResW = 32;
  localparam int MagW = 48;  // Holds every intermediate magnitude.
  localparam int CntW = $clog2(MagW);

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_INC = 3'd3;
  localparam logic [2:0] ACT_DEC = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_G1, S_G1W, S_D1, S_D1W, S_D2, S_D2W,
    S_ML, S_MT1, S_MT2, S_SUM,
    S_MPN, S_MPD,
    S_G2, S_G2W, S_D3, S_D3W, S_D4, S_D4W,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {DS_SD, DS_DB, DS_RN, DS_RD} divsel_e;
  typedef enum logic [2:0] {MS_L, MS_T1, MS_T2, MS_PN, MS_PD} mulsel_e;

  typedef struct packed {
    logic    load;
    logic    gcd_start;
    logic    gcd_sel;    // Low: the two denominators; high: the raw result.
    logic    div_start;
    logic    div_cap;
    divsel_e div_sel;
    logic    mul_en;
    mulsel_e mul_sel;
    logic    sum_en;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic zero_den;
    logic noop;
    logic is_mul;
    logic gcd_done;
    logic div_done;
    logic out_full;
  } sts_t;

endpackage

[src/rfa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational fraction ALU channels
// Operand and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rfa_in_if;
  logic              valid;
  logic              ready;
  logic        [2:0] action;
  logic signed [15:0] num_a;
  logic signed [15:0] den_a;
  logic signed [15:0] num_b;
  logic signed [15:0] den_b;
  modport source(output valid, action, num_a, den_a, num_b, den_b, input ready);
  modport sink(input valid, action, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic        [30:0] res_den;
  logic        [1:0]  status;
  modport source(output valid, res_num, res_den, status, input ready);
  modport sink(input valid, res_num, res_den, status, output ready);
endinterface

[src/rational_fraction_alu.sv]
`timescale 1ns / 1ps
// Order of work: an error or an unused action passes from the check state to
// the done state and then to the result register. A multiply takes one gcd
// run and two divisions. Add, subtract, increment and decrement take two gcd
// runs and four divisions.
// Throughput: one word at a time; the gcd unit and the divider set the rate.
// Reset: rst_ni clears the controller, the result valid flag and the store.
// ----------------------------------------------------------------------------
// Rational fraction ALU
// Adds, subtracts and multiplies signed fractions or accumulates into a
// running fraction, reducing every result by its gcd.
// ----------------------------------------------------------------------------
module rational_fraction_alu import rfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rfa_in_if.sink    in_i,
  rfa_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller accepts a word only when idle; the result register lets
  // the next word in while an earlier result still waits to be taken.
  rfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i(sts),
    .cmd_o(cmd)
  );

  // The datapath holds the operands, the store and the shared arithmetic.
  rfa_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .action_i(in_i.action),
    .num_a_i(in_i.num_a), .den_a_i(in_i.den_a),
    .num_b_i(in_i.num_b), .den_b_i(in_i.den_b),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .res_num_o(out_o.res_num), .res_den_o(out_o.res_den),
    .status_o(out_o.status)
  );

  // A word in flight keeps the input closed on the following cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken twice in a row");

  // Finishing a word always presents a result.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid)
    else $error("finished word not presented");

  // Any error status carries a zero fraction.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_OVERFLOW || out_o.status == ST_ZERO_DEN))
    |-> (out_o.res_num == '0 && out_o.res_den == '0))
    else $error("error status with nonzero fraction");

endmodule

[src/rfa_gcd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational fraction ALU gcd unit
// Binary gcd, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module rfa_gcd import rfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MagW-1:0] a_i,
  input  logic [MagW-1:0] b_i,
  output logic            done_o,
  output logic [MagW-1:0] res_o
);

  logic [MagW-1:0] x_q, x_d, y_q, y_d, res_q, res_d;
  logic [CntW-1:0] k_q, k_d;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    res_d = res_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d = a_i;
      y_d = b_i;
      k_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      priority if (x_q == '0) begin
        res_d = y_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (y_q == '0) begin
        res_d = x_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q >= y_q) begin
        x_d = x_q - y_q;
      end else begin
        y_d = y_q - x_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[src/rfa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational fraction ALU divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_div import rfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MagW-1:0] dividend_i,
  input  logic [MagW-1:0] divisor_i,
  output logic            done_o,
  output logic [MagW-1:0] quot_o
);

  logic [MagW:0]   rem_q, rem_d, trial;
  logic [MagW-1:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[MagW-1:0], quo_q[MagW-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[src/rfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational fraction ALU controller
// Sequences gcd, division, multiply and sum steps of the datapath.
// ----------------------------------------------------------------------------
module rfa_ctrl import rfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        priority if (sts_i.zero_den || sts_i.noop) state_d = S_DONE;
        else if (sts_i.is_mul) state_d = S_MPN;
        else state_d = S_G1;
      end
      S_G1:    state_d = S_G1W;
      S_G1W:   if (sts_i.gcd_done) state_d = S_D1;
      S_D1:    state_d = S_D1W;
      S_D1W:   if (sts_i.div_done) state_d = S_D2;
      S_D2:    state_d = S_D2W;
      S_D2W:   if (sts_i.div_done) state_d = S_ML;
      S_ML:    state_d = S_MT1;
      S_MT1:   state_d = S_MT2;
      S_MT2:   state_d = S_SUM;
      S_SUM:   state_d = S_G2;
      S_MPN:   state_d = S_MPD;
      S_MPD:   state_d = S_G2;
      S_G2:    state_d = S_G2W;
      S_G2W:   if (sts_i.gcd_done) state_d = S_D3;
      S_D3:    state_d = S_D3W;
      S_D3W:   if (sts_i.div_done) state_d = S_D4;
      S_D4:    state_d = S_D4W;
      S_D4W:   if (sts_i.div_done) state_d = S_DONE;
      S_DONE:  if (!sts_i.out_full) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DS_SD;
    cmd_o.mul_sel = MS_L;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE:  cmd_o.load = in_valid_i;
      S_G1:    cmd_o.gcd_start = 1'b1;
      S_D1:    begin cmd_o.div_start = 1'b1; cmd_o.div_sel = DS_SD; end
      S_D1W:   begin cmd_o.div_cap = 1'b1; cmd_o.div_sel = DS_SD; end
      S_D2:    begin cmd_o.div_start = 1'b1; cmd_o.div_sel = DS_DB; end
      S_D2W:   begin cmd_o.div_cap = 1'b1; cmd_o.div_sel = DS_DB; end
      S_ML:    begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_L; end
      S_MT1:   begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_T1; end
      S_MT2:   begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_T2; end
      S_SUM:   cmd_o.sum_en = 1'b1;
      S_MPN:   begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_PN; end
      S_MPD:   begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_PD; end
      S_G2:    begin cmd_o.gcd_start = 1'b1; cmd_o.gcd_sel = 1'b1; end
      S_D3:    begin cmd_o.div_start = 1'b1; cmd_o.div_sel = DS_RN; end
      S_D3W:   begin cmd_o.div_cap = 1'b1; cmd_o.div_sel = DS_RN; end
      S_D4:    begin cmd_o.div_start = 1'b1; cmd_o.div_sel = DS_RD; end
      S_D4W:   begin cmd_o.div_cap = 1'b1; cmd_o.div_sel = DS_RD; end
      S_DONE:  cmd_o.finish = !sts_i.out_full;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

[src/rfa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational fraction ALU datapath
// Operand registers, running store, shared multiplier, gcd and divider units
// and the result word register.
// ----------------------------------------------------------------------------
module rfa_dp import rfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [2:0]             action_i,
  input  logic signed [OpW-1:0]  num_a_i,
  input  logic signed [OpW-1:0]  den_a_i,
  input  logic signed [OpW-1:0]  num_b_i,
  input  logic signed [OpW-1:0]  den_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ResW-1:0] res_num_o,
  output logic [ResW-2:0]        res_den_o,
  output logic [1:0]             status_o
);

  // Running store.
  logic signed [ResW-1:0] acc_num_q;
  logic [ResW-2:0]        acc_den_q;
  logic                   acc_loaded_q;

  // Captured operands as sign and magnitude.
  logic [2:0]      act_q;
  logic            zd_q, noop_q;
  logic [ResW-1:0] sn_mag_q, sd_q;
  logic            sn_neg_q, nb_neg_q;
  logic [OpW-1:0]  nb_mag_q, db_q;

  // Intermediates.
  logic [ResW-1:0] q1_q;
  logic [OpW-1:0]  q2_q;
  logic [MagW-1:0] t1_q, t2_q, rn_mag_q, rd_q;
  logic            rn_neg_q;

  // Result word.
  logic                   ovalid_q;
  logic signed [ResW-1:0] onum_q;
  logic [ResW-2:0]        oden_q;
  logic [1:0]             ost_q;

  logic [OpW-1:0] na_mag, da_mag, nb_mag, db_mag;
  logic           use_acc, is_acc;
  logic [ResW-1:0] acc_mag;

  assign na_mag = num_a_i[OpW-1] ? OpW'(-num_a_i) : OpW'(num_a_i);
  assign da_mag = den_a_i[OpW-1] ? OpW'(-den_a_i) : OpW'(den_a_i);
  assign nb_mag = num_b_i[OpW-1] ? OpW'(-num_b_i) : OpW'(num_b_i);
  assign db_mag = den_b_i[OpW-1] ? OpW'(-den_b_i) : OpW'(den_b_i);
  assign is_acc = (action_i == ACT_INC) || (action_i == ACT_DEC);
  assign use_acc = is_acc && acc_loaded_q;
  assign acc_mag = acc_num_q[ResW-1] ? ResW'(-acc_num_q) : ResW'(acc_num_q);

  // Shared units.
  logic            gcd_done, div_done;
  logic [MagW-1:0] gcd_a, gcd_b, gcd_res, div_num, quot;

  assign gcd_a = cmd_i.gcd_sel ? rn_mag_q : MagW'(sd_q);
  assign gcd_b = cmd_i.gcd_sel ? rd_q : MagW'(db_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      DS_SD:   div_num = MagW'(sd_q);
      DS_DB:   div_num = MagW'(db_q);
      DS_RN:   div_num = rn_mag_q;
      DS_RD:   div_num = rd_q;
      default: div_num = rd_q;
    endcase
  end

  rfa_gcd u_gcd (
    .clk_i, .rst_ni, .start_i(cmd_i.gcd_start), .a_i(gcd_a), .b_i(gcd_b),
    .done_o(gcd_done), .res_o(gcd_res)
  );

  rfa_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(div_num),
    .divisor_i(gcd_res), .done_o(div_done), .quot_o(quot)
  );

  // Multiplier, 32 by 16 bits.
  logic [ResW-1:0] mul_a;
  logic [OpW-1:0]  mul_b;
  logic [MagW-1:0] prod;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_L:    begin mul_a = q1_q;     mul_b = db_q;     end
      MS_T1:   begin mul_a = sn_mag_q; mul_b = q2_q;     end
      MS_T2:   begin mul_a = q1_q;     mul_b = nb_mag_q; end
      MS_PN:   begin mul_a = sn_mag_q; mul_b = nb_mag_q; end
      MS_PD:   begin mul_a = sd_q;     mul_b = db_q;     end
      default: begin mul_a = '0;       mul_b = '0;       end
    endcase
    prod = MagW'(mul_a) * MagW'(mul_b);
  end

  // Signed sum of the two scaled numerators.
  logic signed [MagW:0] s1, s2, sum;
  assign s1  = sn_neg_q ? -$signed({1'b0, t1_q}) : $signed({1'b0, t1_q});
  assign s2  = nb_neg_q ? -$signed({1'b0, t2_q}) : $signed({1'b0, t2_q});
  assign sum = s1 + s2;

  // Final range check and result word.
  logic                   fit;
  logic [1:0]             rst_st;
  logic signed [ResW-1:0] rnum;
  localparam logic [MagW-1:0] NegLim = MagW'(1) << (ResW - 1);

  assign fit = (rd_q[MagW-1:ResW-1] == '0) &&
               (rn_neg_q ? (rn_mag_q <= NegLim) : (rn_mag_q[MagW-1:ResW-1] == '0));
  assign rnum = rn_neg_q ? -$signed(rn_mag_q[ResW-1:0]) : $signed(rn_mag_q[ResW-1:0]);

  always_comb begin
    priority if (zd_q) rst_st = ST_ZERO_DEN;
    else if (noop_q || fit) rst_st = ST_OK;
    else rst_st = ST_OVERFLOW;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      noop_q   <= (action_i > ACT_DEC);
      zd_q     <= (action_i <= ACT_DEC) &&
                  ((den_b_i == '0) || (!use_acc && (den_a_i == '0)));
      sn_mag_q <= use_acc ? acc_mag : ResW'(na_mag);
      sn_neg_q <= use_acc ? acc_num_q[ResW-1] : (num_a_i[OpW-1] ^ den_a_i[OpW-1]);
      sd_q     <= use_acc ? ResW'(acc_den_q) : ResW'(da_mag);
      nb_mag_q <= nb_mag;
      nb_neg_q <= num_b_i[OpW-1] ^ den_b_i[OpW-1] ^
                  ((action_i == ACT_SUB) || (action_i == ACT_DEC));
      db_q     <= db_mag;
    end
    if (cmd_i.div_cap && div_done) begin
      unique case (cmd_i.div_sel)
        DS_SD:   q1_q <= quot[ResW-1:0];
        DS_DB:   q2_q <= quot[OpW-1:0];
        DS_RN:   rn_mag_q <= quot;
        DS_RD:   rd_q <= quot;
        default: rd_q <= quot;
      endcase
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MS_L, MS_PD: rd_q <= prod;
        MS_T1:       t1_q <= prod;
        MS_T2:       t2_q <= prod;
        MS_PN:       begin rn_mag_q <= prod; rn_neg_q <= sn_neg_q ^ nb_neg_q; end
        default:     t1_q <= prod;
      endcase
    end
    if (cmd_i.sum_en) begin
      rn_neg_q <= sum[MagW];
      rn_mag_q <= sum[MagW] ? MagW'(-sum) : MagW'(sum);
    end
    if (cmd_i.finish) begin
      ost_q <= rst_st;
      if (rst_st == ST_OK && !noop_q) begin
        onum_q <= rnum;
        oden_q <= rd_q[ResW-2:0];
      end else begin
        onum_q <= '0;
        oden_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q     <= 1'b0;
      acc_num_q    <= '0;
      acc_den_q    <= '0;
      acc_loaded_q <= 1'b0;
    end else begin
      if (cmd_i.finish) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (cmd_i.finish && rst_st == ST_OK && !noop_q) begin
        if ((act_q == ACT_INC) || (act_q == ACT_DEC)) begin
          acc_num_q    <= rnum;
          acc_den_q    <= rd_q[ResW-2:0];
          acc_loaded_q <= 1'b1;
        end else begin
          acc_num_q    <= '0;
          acc_den_q    <= '0;
          acc_loaded_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.zero_den = zd_q;
  assign sts_o.noop     = noop_q;
  assign sts_o.is_mul   = (act_q == ACT_MUL);
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.div_done = div_done;
  assign sts_o.out_full = ovalid_q && !out_ready_i;

  assign out_valid_o = ovalid_q;
  assign res_num_o   = onum_q;
  assign res_den_o   = oden_q;
  assign status_o    = ost_q;

endmodule
